FILE: rtl/sct_pkg.sv
// Shared codes, types and command/status bundles for the socket channel table.
package sct_pkg;

  // Request codes
  localparam logic [2:0] REQ_OPEN     = 3'd0;
  localparam logic [2:0] REQ_ADD      = 3'd1;
  localparam logic [2:0] REQ_FIND_IN  = 3'd2;
  localparam logic [2:0] REQ_FIND_OUT = 3'd3;
  localparam logic [2:0] REQ_CLOSE    = 3'd4;
  localparam logic [2:0] REQ_REMOVE   = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADSOCK  = 3'd1;
  localparam logic [2:0] ST_BUSY     = 3'd2;
  localparam logic [2:0] ST_NOTOPEN  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  // Which fields a result beat carries
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_ENTRY
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic       clear_en;
    logic       latch;
    logic       slot_rd;
    logic       slot_rd_best;
    logic       slot_wr;
    logic       slot_open_bit;
    logic       scan_start;
    logic       ent_wr_add;
    logic       ent_wr_del;
    logic       cnt_inc;
    logic       out_load;
    logic [2:0] out_status;
    kind_t      out_kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       clear_done;
    logic [2:0] req;
    logic       sock_bad;
    logic       slot_open;
    logic       scan_done;
    logic       found;
    logic       cnt_max;
    logic       out_busy;
  } sts_t;

endpackage

FILE: rtl/socket_channel_table_unit.sv
// Socket channel table: top level joining the sequencer and the datapath.
// Handles one request at a time. A result beat is offered in the cycle after its result
// is loaded into the output register. Open requests and requests rejected on the socket
// number or slot state finish without a walk of the channel store. Add, find, close and
// remove walk the channel store through its single read port, one entry per cycle. A find
// by out that hits reads the owner's slot after the walk; one that misses does not.
// Unknown request codes are dropped with no result beat. A result still held in the output
// register by out_stall delays the load of the next one. After reset a clearing pass over
// max(SOCKETS, CHANNELS) addresses empties the slot and channel stores; no request beat is
// taken during it. A finished result waits in the output register while the next request
// is accepted.
module socket_channel_table_unit
  import sct_pkg::*;
#(
  parameter int SOCKETS  = 1024,
  parameter int CHANNELS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_socket_id,
  input  logic [15:0] in_queue_handle,
  input  logic [31:0] in_channel_in,
  input  logic [31:0] in_channel_out,
  input  logic [15:0] in_cipher_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [9:0]  out_found_socket,
  output logic [31:0] out_found_in,
  output logic [31:0] out_found_out,
  output logic [15:0] out_found_cipher,
  output logic [15:0] out_found_queue
);

  cmd_t cmd;
  sts_t sts;

  sct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sct_dp #(.SOCKETS(SOCKETS), .CHANNELS(CHANNELS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req_type),
    .in_socket_id     (in_socket_id),
    .in_queue_handle  (in_queue_handle),
    .in_channel_in    (in_channel_in),
    .in_channel_out   (in_channel_out),
    .in_cipher_handle (in_cipher_handle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_found_socket (out_found_socket),
    .out_found_in     (out_found_in),
    .out_found_out    (out_found_out),
    .out_found_cipher (out_found_cipher),
    .out_found_queue  (out_found_queue)
  );

endmodule

FILE: rtl/sct_ram.sv
// Generic simple dual-port RAM with registered read.
module sct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/sct_ctrl.sv
// Request sequencer for the socket channel table.
module sct_ctrl
  import sct_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_CHECK  = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_POST   = 8'b0010_0000,
    S_QWAIT  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] res_st_r, res_st_nxt;
  kind_t      res_kind_r, res_kind_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt         = state_r;
    res_st_nxt        = res_st_r;
    res_kind_nxt      = res_kind_r;
    cmd               = '0;
    cmd.out_kind      = res_kind_r;
    cmd.out_status    = res_st_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.req > REQ_REMOVE) begin
          state_nxt = S_IDLE;
        end else if (sts.req == REQ_FIND_OUT) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else if (sts.sock_bad) begin
          res_st_nxt   = ST_BADSOCK;
          res_kind_nxt = KIND_ZERO;
          state_nxt    = S_FINISH;
        end else begin
          cmd.slot_rd = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.req == REQ_OPEN) begin
          state_nxt = S_FINISH;
          if (sts.slot_open) begin
            res_st_nxt   = ST_BUSY;
            res_kind_nxt = KIND_ZERO;
          end else begin
            cmd.slot_wr       = 1'b1;
            cmd.slot_open_bit = 1'b1;
            res_st_nxt        = ST_OK;
            res_kind_nxt      = KIND_OPEN;
          end
        end else if (!sts.slot_open && sts.req != REQ_FIND_IN) begin
          res_st_nxt   = ST_NOTOPEN;
          res_kind_nxt = KIND_ZERO;
          state_nxt    = S_FINISH;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        state_nxt    = S_FINISH;
        res_st_nxt   = ST_OK;
        res_kind_nxt = KIND_ENTRY;
        if (sts.req == REQ_CLOSE) begin
          cmd.slot_wr  = 1'b1;
          res_kind_nxt = KIND_CLOSE;
        end else if (sts.req == REQ_ADD) begin
          if (!sts.found || sts.cnt_max) begin
            res_st_nxt   = ST_FULL;
            res_kind_nxt = KIND_ZERO;
          end else begin
            cmd.ent_wr_add = 1'b1;
            cmd.cnt_inc    = 1'b1;
          end
        end else if (!sts.found) begin
          res_st_nxt   = ST_NOTFOUND;
          res_kind_nxt = KIND_ZERO;
        end else if (sts.req == REQ_FIND_OUT) begin
          cmd.slot_rd_best = 1'b1;
          state_nxt        = S_QWAIT;
        end else if (sts.req == REQ_REMOVE) begin
          cmd.ent_wr_del = 1'b1;
        end
      end
      S_QWAIT: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      res_st_r   <= ST_OK;
      res_kind_r <= KIND_ZERO;
    end else begin
      state_r    <= state_nxt;
      res_st_r   <= res_st_nxt;
      res_kind_r <= res_kind_nxt;
    end
  end

endmodule

FILE: rtl/sct_dp.sv
// Datapath: request registers, slot and entry stores, scan unit, result register.
module sct_dp
  import sct_pkg::*;
#(
  parameter int SOCKETS  = 1024,
  parameter int CHANNELS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_socket_id,
  input  logic [15:0] in_queue_handle,
  input  logic [31:0] in_channel_in,
  input  logic [31:0] in_channel_out,
  input  logic [15:0] in_cipher_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [9:0]  out_found_socket,
  output logic [31:0] out_found_in,
  output logic [31:0] out_found_out,
  output logic [15:0] out_found_cipher,
  output logic [15:0] out_found_queue
);

  localparam int SW   = $clog2(SOCKETS);
  localparam int CW   = $clog2(CHANNELS);
  localparam int MAXD = (SOCKETS > CHANNELS) ? SOCKETS : CHANNELS;
  localparam int CLRW = $clog2(MAXD);
  localparam logic [CW-1:0]   LAST    = CW'(CHANNELS - 1);
  localparam logic [CLRW-1:0] CLR_END = CLRW'(MAXD - 1);

  typedef struct packed {
    logic          v;
    logic [SW-1:0] sock;
    logic [31:0]   cin;
    logic [31:0]   cout;
    logic [15:0]   ciph;
    logic [31:0]   stamp;
  } ent_t;

  localparam int EW = $bits(ent_t);

  // Request registers
  logic [2:0]  req_r;
  logic [15:0] sock_r, queue_r, ciph_r;
  logic [31:0] cin_r, cout_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r   <= in_req_type;
      sock_r  <= in_socket_id;
      queue_r <= in_queue_handle;
      cin_r   <= in_channel_in;
      cout_r  <= in_channel_out;
      ciph_r  <= in_cipher_handle;
    end
  end

  logic [SW-1:0] sock_idx;
  assign sock_idx = sock_r[SW-1:0];

  // Clearing pass after reset
  logic [CLRW-1:0] clr_cnt_r;
  logic [31:0]     clr_ext;
  assign clr_ext = 32'(clr_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Scan address generator and read pipeline
  logic          scan_act_r, pend_r;
  logic [CW-1:0] scan_cnt_r, pend_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_act_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      pend_r <= scan_act_r;
      if (cmd.scan_start) begin
        scan_act_r <= 1'b1;
      end else if (scan_act_r && scan_cnt_r == LAST) begin
        scan_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= scan_cnt_r;
    if (cmd.scan_start) begin
      scan_cnt_r <= '0;
    end else if (scan_act_r) begin
      scan_cnt_r <= scan_cnt_r + 1'b1;
    end
  end

  // Best match tracking
  logic          found_r;
  logic [CW-1:0] best_idx_r;
  logic [31:0]   best_stamp_r, best_in_r, best_out_r;
  logic [SW-1:0] best_sock_r;
  logic [15:0]   best_ciph_r;
  logic [31:0]   add_cnt_r;

  // Stores
  logic [16:0]   slot_rd_data;
  logic          slot_wr_en;
  logic [SW-1:0] slot_wr_addr;
  logic [16:0]   slot_wr_data;
  logic [SW-1:0] slot_rd_addr;

  logic [EW-1:0] ent_rd_raw;
  ent_t          ent_d, ent_new;
  logic          ent_wr_en;
  logic [CW-1:0] ent_wr_addr;
  logic [EW-1:0] ent_wr_data;

  assign ent_d = ent_t'(ent_rd_raw);

  // Hit test on the entry just read
  logic key_hit, take, close_clr;

  always_comb begin
    unique case (req_r)
      REQ_FIND_OUT: key_hit = ent_d.v && ent_d.cout == cout_r;
      REQ_ADD:      key_hit = !ent_d.v && !found_r;
      REQ_CLOSE:    key_hit = ent_d.v && ent_d.sock == sock_idx;
      default:      key_hit = ent_d.v && ent_d.sock == sock_idx && ent_d.cin == cin_r;
    endcase
    take = pend_r && key_hit && req_r != REQ_CLOSE &&
           (req_r == REQ_ADD || !found_r || ent_d.stamp > best_stamp_r);
    close_clr = pend_r && key_hit && req_r == REQ_CLOSE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.scan_start) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r   <= pend_addr_r;
      best_stamp_r <= ent_d.stamp;
      best_sock_r  <= ent_d.sock;
      best_in_r    <= ent_d.cin;
      best_out_r   <= ent_d.cout;
      best_ciph_r  <= ent_d.ciph;
    end else if (cmd.ent_wr_add) begin
      best_sock_r <= sock_idx;
      best_in_r   <= cin_r;
      best_out_r  <= cout_r;
      best_ciph_r <= ciph_r;
    end
  end

  // Add counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      add_cnt_r <= add_cnt_r + 32'd1;
    end
  end

  // Slot store ports
  always_comb begin
    if (cmd.clear_en) begin
      slot_wr_en   = clr_ext < 32'(SOCKETS);
      slot_wr_addr = clr_cnt_r[SW-1:0];
      slot_wr_data = '0;
    end else begin
      slot_wr_en   = cmd.slot_wr;
      slot_wr_addr = sock_idx;
      slot_wr_data = {cmd.slot_open_bit, queue_r};
    end
    slot_rd_addr = cmd.slot_rd_best ? best_sock_r : sock_idx;
  end

  sct_ram #(.WIDTH(17), .DEPTH(SOCKETS)) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data),
    .rd_en   (cmd.slot_rd | cmd.slot_rd_best),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data)
  );

  // Entry store ports
  always_comb begin
    ent_new.v     = 1'b1;
    ent_new.sock  = sock_idx;
    ent_new.cin   = cin_r;
    ent_new.cout  = cout_r;
    ent_new.ciph  = ciph_r;
    ent_new.stamp = add_cnt_r;
    ent_wr_en     = 1'b0;
    ent_wr_addr   = best_idx_r;
    ent_wr_data   = '0;
    priority if (cmd.clear_en) begin
      ent_wr_en   = clr_ext < 32'(CHANNELS);
      ent_wr_addr = clr_cnt_r[CW-1:0];
    end else if (close_clr) begin
      ent_wr_en   = 1'b1;
      ent_wr_addr = pend_addr_r;
    end else if (cmd.ent_wr_add) begin
      ent_wr_en   = 1'b1;
      ent_wr_data = EW'(ent_new);
    end else if (cmd.ent_wr_del) begin
      ent_wr_en = 1'b1;
    end else begin
      ent_wr_en = 1'b0;
    end
  end

  sct_ram #(.WIDTH(EW), .DEPTH(CHANNELS)) u_ent_ram (
    .clk     (clk),
    .wr_en   (ent_wr_en),
    .wr_addr (ent_wr_addr),
    .wr_data (ent_wr_data),
    .rd_en   (scan_act_r),
    .rd_addr (scan_cnt_r),
    .rd_data (ent_rd_raw)
  );

  // Result register
  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [9:0]  fsock_r;
  logic [31:0] fin_r, fout_r;
  logic [15:0] fciph_r, fqueue_r;
  logic [31:0] best_sock_ext;
  assign best_sock_ext = 32'(best_sock_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r <= cmd.out_status;
      fsock_r  <= '0;
      fin_r    <= '0;
      fout_r   <= '0;
      fciph_r  <= '0;
      fqueue_r <= '0;
      unique case (cmd.out_kind)
        KIND_OPEN: begin
          fsock_r  <= sock_r[9:0];
          fqueue_r <= queue_r;
        end
        KIND_CLOSE: begin
          fsock_r  <= sock_r[9:0];
          fqueue_r <= slot_rd_data[15:0];
        end
        KIND_ENTRY: begin
          fsock_r  <= best_sock_ext[9:0];
          fin_r    <= best_in_r;
          fout_r   <= best_out_r;
          fciph_r  <= best_ciph_r;
          fqueue_r <= slot_rd_data[15:0];
        end
        default: begin
          fsock_r <= '0;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_found_socket = fsock_r;
  assign out_found_in     = fin_r;
  assign out_found_out    = fout_r;
  assign out_found_cipher = fciph_r;
  assign out_found_queue  = fqueue_r;

  // Status to controller
  assign sts.clear_done = clr_cnt_r == CLR_END;
  assign sts.req        = req_r;
  assign sts.sock_bad   = {1'b0, sock_r} >= 17'(SOCKETS);
  assign sts.slot_open  = slot_rd_data[16];
  assign sts.scan_done  = pend_r && pend_addr_r == LAST;
  assign sts.found      = found_r;
  assign sts.cnt_max    = &add_cnt_r;
  assign sts.out_busy   = out_valid_r && out_stall;

endmodule

FILE: tb/sv/socket_channel_table_unit_tb.sv
// Testbench for socket_channel_table_unit: random requests checked against a cycle-free table model.
`timescale 1ns / 1ps

module socket_channel_table_unit_tb;
  import sct_pkg::*;

  localparam int SOCKETS  = 1024;
  localparam int CHANNELS = 256;
  localparam int N_RANDOM = 1130;

  typedef struct packed {
    logic [2:0]  req;
    logic [15:0] sock;
    logic [15:0] queue;
    logic [31:0] cin;
    logic [31:0] cout;
    logic [15:0] ciph;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  sock;
    logic [31:0] cin;
    logic [31:0] cout;
    logic [15:0] ciph;
    logic [15:0] queue;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = '0;
  logic [15:0] in_socket_id = '0;
  logic [15:0] in_queue_handle = '0;
  logic [31:0] in_channel_in = '0;
  logic [31:0] in_channel_out = '0;
  logic [15:0] in_cipher_handle = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [9:0]  out_found_socket;
  logic [31:0] out_found_in;
  logic [31:0] out_found_out;
  logic [15:0] out_found_cipher;
  logic [15:0] out_found_queue;

  socket_channel_table_unit #(.SOCKETS(SOCKETS), .CHANNELS(CHANNELS)) uut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the table
  logic        sh_open   [SOCKETS];
  logic [15:0] sh_queue  [SOCKETS];
  logic        sh_valid  [CHANNELS];
  logic [9:0]  sh_sock   [CHANNELS];
  logic [31:0] sh_in     [CHANNELS];
  logic [31:0] sh_out    [CHANNELS];
  logic [15:0] sh_ciph   [CHANNELS];
  logic [31:0] sh_stamp  [CHANNELS];
  logic [31:0] sh_adds;

  request_t pending_reqs[$];
  reply_t   expected_replies[$];
  int       errors = 0;
  int       replies_seen = 0;
  int       req_count[8];
  logic     calm = 1'b0;
  logic     hold_off = 1'b0;
  int       in_gap = 0;
  int       out_gap = 0;

  function automatic reply_t entry_reply(int e);
    reply_t r;
    r = '{ST_OK, sh_sock[e], sh_in[e], sh_out[e], sh_ciph[e], sh_queue[sh_sock[e]]};
    return r;
  endfunction

  // Latest matching live channel, or -1
  function automatic int latest_match(logic by_sock, logic [15:0] sock, logic [31:0] key);
    int best;
    logic hit;
    best = -1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (sh_valid[i]) begin
        hit = by_sock ? (sh_sock[i] == sock && sh_in[i] == key) : (sh_out[i] == key);
        if (hit && (best < 0 || sh_stamp[i] > sh_stamp[best])) best = i;
      end
    end
    return best;
  endfunction

  // Apply one accepted request to the shadow table and queue its reply
  task automatic table_predict(request_t q);
    reply_t r;
    int e;
    r = '0;
    if (q.req > REQ_REMOVE) return;
    if (q.req == REQ_FIND_OUT) begin
      e = latest_match(1'b0, '0, q.cout);
      if (e < 0) r.status = ST_NOTFOUND;
      else r = entry_reply(e);
    end else if (q.sock >= SOCKETS) begin
      r.status = ST_BADSOCK;
    end else begin
      case (q.req)
        REQ_OPEN: begin
          if (sh_open[q.sock]) r.status = ST_BUSY;
          else begin
            sh_open[q.sock] = 1'b1;
            sh_queue[q.sock] = q.queue;
            r = '{ST_OK, q.sock[9:0], 32'd0, 32'd0, 16'd0, q.queue};
          end
        end
        REQ_ADD: begin
          if (!sh_open[q.sock]) r.status = ST_NOTOPEN;
          else begin
            e = -1;
            for (int i = CHANNELS - 1; i >= 0; i--) if (!sh_valid[i]) e = i;
            if (sh_adds == '1 || e < 0) r.status = ST_FULL;
            else begin
              sh_valid[e] = 1'b1;
              sh_sock[e] = q.sock[9:0];
              sh_in[e] = q.cin;
              sh_out[e] = q.cout;
              sh_ciph[e] = q.ciph;
              sh_stamp[e] = sh_adds;
              sh_adds = sh_adds + 1;
              r = entry_reply(e);
            end
          end
        end
        REQ_FIND_IN: begin
          e = latest_match(1'b1, q.sock, q.cin);
          if (e < 0) r.status = ST_NOTFOUND;
          else r = entry_reply(e);
        end
        REQ_CLOSE: begin
          if (!sh_open[q.sock]) r.status = ST_NOTOPEN;
          else begin
            for (int i = 0; i < CHANNELS; i++)
              if (sh_valid[i] && sh_sock[i] == q.sock) sh_valid[i] = 1'b0;
            sh_open[q.sock] = 1'b0;
            r = '{ST_OK, q.sock[9:0], 32'd0, 32'd0, 16'd0, sh_queue[q.sock]};
          end
        end
        default: begin
          if (!sh_open[q.sock]) r.status = ST_NOTOPEN;
          else begin
            e = latest_match(1'b1, q.sock, q.cin);
            if (e < 0) r.status = ST_NOTFOUND;
            else begin
              r = entry_reply(e);
              sh_valid[e] = 1'b0;
            end
          end
        end
      endcase
    end
    expected_replies.push_back(r);
  endtask

  // Driver: advance to the next request once the current beat is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        req_count[in_req_type]++;
        table_predict('{in_req_type, in_socket_id, in_queue_handle, in_channel_in,
                        in_channel_out, in_cipher_handle});
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(1, 14) - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          request_t q;
          q = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= q.req;
          in_socket_id <= q.sock;
          in_queue_handle <= q.queue;
          in_channel_in <= q.cin;
          in_channel_out <= q.cout;
          in_cipher_handle <= q.ciph;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        reply_t got, want;
        got = '{out_status, out_found_socket, out_found_in, out_found_out,
                out_found_cipher, out_found_queue};
        replies_seen++;
        if (expected_replies.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at result %0d: expected %p got %p", replies_seen, want, got);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= hold_off;
      end
    end
  end

  // Long receiver hold-off while requests keep coming
  initial begin
    wait (rst_n);
    repeat (40000) @(posedge clk);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #40ms;
    $display("socket_channel_table_unit_tb: errors");
    $finish;
  end

  task automatic add_req(logic [2:0] req, logic [15:0] sock, logic [15:0] queue,
                         logic [31:0] cin, logic [31:0] cout, logic [15:0] ciph);
    pending_reqs.push_back('{req, sock, queue, cin, cout, ciph});
  endtask

  function automatic logic [15:0] pick_sock();
    int k;
    k = $urandom_range(0, 99);
    if (k < 5) return 16'($urandom_range(SOCKETS, 65535));
    if (k < 15) return 16'($urandom);
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'd3;
      4: return 16'd500;
      5: return 16'd1021;
      6: return 16'd1022;
      default: return 16'd1023;
    endcase
  endfunction

  function automatic logic [31:0] pick_id();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return 32'($urandom_range(0, 5)) ^ {32{$urandom_range(0, 1) == 1}};
  endfunction

  initial begin
    logic [2:0] r;
    int k;
    for (int i = 0; i < SOCKETS; i++) begin sh_open[i] = 1'b0; sh_queue[i] = '0; end
    for (int i = 0; i < CHANNELS; i++) sh_valid[i] = 1'b0;
    sh_adds = '0;
    foreach (req_count[i]) req_count[i] = 0;

    // Directed: extremes, each request kind, errors, duplicates, unknown codes
    add_req(REQ_OPEN, 16'hFFFF, 16'h1234, 0, 0, 0);
    add_req(REQ_ADD, 16'd1024, 0, 1, 1, 1);
    add_req(REQ_OPEN, 16'd0, 16'h0000, 0, 0, 0);
    add_req(REQ_OPEN, 16'd0, 16'hAAAA, 0, 0, 0);
    add_req(REQ_OPEN, 16'd1023, 16'hFFFF, 0, 0, 0);
    add_req(REQ_ADD, 16'd5, 0, 7, 7, 7);
    add_req(REQ_ADD, 16'd0, 0, 32'd0, 32'd0, 16'd0);
    add_req(REQ_ADD, 16'd1023, 0, '1, '1, '1);
    add_req(REQ_ADD, 16'd0, 0, 32'd0, '1, 16'h5555);
    add_req(REQ_FIND_IN, 16'd0, 0, 32'd0, 0, 0);
    add_req(REQ_FIND_IN, 16'd5, 0, 32'd0, 0, 0);
    add_req(REQ_FIND_IN, 16'd1024, 0, 32'd0, 0, 0);
    add_req(REQ_FIND_OUT, 16'hFFFF, 0, 0, '1, 0);
    add_req(REQ_FIND_OUT, 16'd0, 0, 0, 32'h12345, 0);
    add_req(REQ_REMOVE, 16'd0, 0, 32'd0, 0, 0);
    add_req(REQ_REMOVE, 16'd0, 0, 32'd0, 0, 0);
    add_req(REQ_REMOVE, 16'd0, 0, 32'd0, 0, 0);
    add_req(REQ_REMOVE, 16'd7, 0, 32'd0, 0, 0);
    add_req(REQ_CLOSE, 16'd7, 0, 0, 0, 0);
    add_req(REQ_CLOSE, 16'd1023, 0, 0, 0, 0);
    add_req(REQ_FIND_OUT, 16'd0, 0, 0, '1, 0);
    add_req(3'd6, 16'd0, 0, 0, 0, 0);
    add_req(3'd7, 16'd0, 0, 0, 0, 0);

    // Random: mixed phases, with an add-heavy stretch that fills the store
    for (int n = 0; n < N_RANDOM; n++) begin
      k = $urandom_range(0, 99);
      if (n >= 300 && n < 650) begin
        r = k < 10 ? REQ_OPEN : k < 75 ? REQ_ADD : k < 85 ? REQ_FIND_IN :
            k < 95 ? REQ_FIND_OUT : REQ_REMOVE;
      end else begin
        r = k < 18 ? REQ_OPEN : k < 48 ? REQ_ADD : k < 63 ? REQ_FIND_IN :
            k < 78 ? REQ_FIND_OUT : k < 86 ? REQ_CLOSE : k < 98 ? REQ_REMOVE :
            3'($urandom_range(6, 7));
      end
      add_req(r, pick_sock(), 16'($urandom), pick_id(), pick_id(), 16'($urandom));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() < 100);
    calm = 1'b1;
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_replies.size() == 0);
    repeat (CHANNELS + 50) @(posedge clk);
    $display("covered %0d opens, %0d adds, %0d finds by in, %0d finds by out,",
             req_count[REQ_OPEN], req_count[REQ_ADD], req_count[REQ_FIND_IN],
             req_count[REQ_FIND_OUT]);
    $display("%0d closes, %0d removes, %0d unknown codes; %0d results checked",
             req_count[REQ_CLOSE], req_count[REQ_REMOVE], req_count[6] + req_count[7],
             replies_seen);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("socket_channel_table_unit_tb: clean");
    end else begin
      $display("socket_channel_table_unit_tb: errors");
    end
    $finish;
  end

endmodule
